FILE: sv/hpq_pkg.sv
// Shared definitions for the binary max-heap priority queue.
// Holds command and status codes, field widths and the control/status
// structures that pass between the controller and the datapath.
package hpq_pkg;

  // Default number of heap entries.
  localparam int DEF_CAPACITY = 15;

  // Fixed widths of the request and result fields.
  localparam int CMD_W     = 2;
  localparam int VAL_W     = 32;
  localparam int RIDX_W    = 4;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 4;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SORT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            res_load;   // start a result: load status code, clear data
    logic [ST_W-1:0] res_code;
    logic            ld_insert;  // take the new value, place hole at the end
    logic            ld_sort;    // sort length from the entry count
    logic            rd_del;     // read root and last entry
    logic            del_take;   // report root, carry last entry down from root
    logic            rd_read;    // read the requested entry
    logic            read_take;  // report the entry read
    logic            up_rd;      // read the parent of the hole
    logic            up_move;    // move parent down into the hole
    logic            dn_rd;      // read both children of the hole
    logic            dn_move;    // move larger child up into the hole
    logic            sort_rd;    // read root and last entry of the unsorted part
    logic            sort_take;  // park root at the end, carry last entry down
    logic            wr_v;       // write the carried value into the hole
    logic            publish;    // load the output register
  } hpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;
    logic pos_zero;
    logic left_out;
    logic up_go;
    logic dn_go;
    logic len_gt1;
  } hpq_stat_t;

endpackage

FILE: sv/hpq_ctrl.sv
// Controller state machine of the heap priority queue.
// Uses hpq_pkg for command codes and the control/status structures;
// drives the datapath through hpq_cmd_t and owns the request handshakes.
module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd_code,
  output logic             out_valid,
  input  logic             out_ready,
  input  hpq_stat_t        stat,
  output hpq_cmd_t         ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_READ_LD  = 4'd1;
  localparam logic [3:0] S_DEL_LD   = 4'd2;
  localparam logic [3:0] S_UP_CHK   = 4'd3;
  localparam logic [3:0] S_UP_CMP   = 4'd4;
  localparam logic [3:0] S_DN_CHK   = 4'd5;
  localparam logic [3:0] S_DN_CMP   = 4'd6;
  localparam logic [3:0] S_SORT_CHK = 4'd7;
  localparam logic [3:0] S_SORT_LD  = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;
  logic       sorting, sorting_next;
  logic       out_valid_next;

  // A new request is taken whenever no operation is in progress,
  // even while the previous result waits in the output register.
  assign in_ready = (state == S_IDLE);

  // Next-state and command decode.
  always_comb begin
    ctl            = '0;
    state_next     = state;
    sorting_next   = sorting;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.res_load = 1'b1;
          ctl.res_code = ST_OK;
          case (cmd_code)
            CMD_INSERT: begin
              if (stat.full) begin
                ctl.res_code = ST_FULL;
                state_next   = S_DONE;
              end else begin
                ctl.ld_insert = 1'b1;
                state_next    = S_UP_CHK;
              end
            end
            CMD_DELETE: begin
              if (stat.empty) begin
                ctl.res_code = ST_EMPTY;
                state_next   = S_DONE;
              end else begin
                ctl.rd_del = 1'b1;
                state_next = S_DEL_LD;
              end
            end
            CMD_SORT: begin
              ctl.ld_sort  = 1'b1;
              sorting_next = 1'b1;
              state_next   = S_SORT_CHK;
            end
            CMD_READ: begin
              if (stat.idx_ok) begin
                ctl.rd_read = 1'b1;
                state_next  = S_READ_LD;
              end else begin
                ctl.res_code = ST_RANGE;
                state_next   = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_READ_LD: begin
        ctl.read_take = 1'b1;
        state_next    = S_DONE;
      end
      S_DEL_LD: begin
        ctl.del_take = 1'b1;
        state_next   = S_DN_CHK;
      end
      // Sift up: one parent read, then a compare and one write per level.
      S_UP_CHK: begin
        if (stat.pos_zero) begin
          ctl.wr_v   = 1'b1;
          state_next = S_DONE;
        end else begin
          ctl.up_rd  = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_go) begin
          ctl.up_move = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          ctl.wr_v   = 1'b1;
          state_next = S_DONE;
        end
      end
      // Sift down: both children read together, then compare and write.
      S_DN_CHK: begin
        if (stat.left_out) begin
          ctl.wr_v   = 1'b1;
          state_next = sorting ? S_SORT_CHK : S_DONE;
        end else begin
          ctl.dn_rd  = 1'b1;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_go) begin
          ctl.dn_move = 1'b1;
          state_next  = S_DN_CHK;
        end else begin
          ctl.wr_v   = 1'b1;
          state_next = sorting ? S_SORT_CHK : S_DONE;
        end
      end
      // Heapsort: repeatedly park the maximum at the end of the unsorted part.
      S_SORT_CHK: begin
        if (stat.len_gt1) begin
          ctl.sort_rd = 1'b1;
          state_next  = S_SORT_LD;
        end else begin
          sorting_next = 1'b0;
          state_next   = S_DONE;
        end
      end
      S_SORT_LD: begin
        ctl.sort_take = 1'b1;
        state_next    = S_DN_CHK;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sorting   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sorting   <= sorting_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The output register is only overwritten when its result has been taken.
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    ctl.publish |-> (!out_valid || out_ready))
    else $error("result published over a pending result");

  // The single memory write port is never asked for two writes at once.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.wr_v, ctl.up_move, ctl.dn_move, ctl.sort_take}))
    else $error("more than one memory write in a cycle");

  // A heapsort never enters the sift-up path.
  a_sort_no_up: assert property (@(posedge clk) disable iff (rst)
    sorting |-> (state != S_UP_CHK && state != S_UP_CMP))
    else $error("sift-up reached during heapsort");
`endif

endmodule

FILE: sv/hpq_dp.sv
// Datapath of the heap priority queue: entry memory, hole position,
// carried value, entry count, compare logic and the result register.
// Uses hpq_pkg; driven by hpq_ctrl through hpq_cmd_t.
module hpq_dp
  import hpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hpq_cmd_t                    ctl,
  output hpq_stat_t                   stat,
  input  logic signed [VAL_W-1:0]     value,
  input  logic        [RIDX_W-1:0]    read_index,
  output logic        [ST_W-1:0]      status,
  output logic signed [VAL_W-1:0]     data,
  output logic        [CNT_OUT_W-1:0] count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = IDX_W + 2;
  localparam int XW    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  // Entry memory: one write port, two registered read ports.
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_a, rd_b;
  logic        [IDX_W-1:0] addr_a, addr_b, wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    wr_en;

  logic        [CNT_W-1:0] entry_count;
  logic        [CNT_W-1:0] len;
  logic        [IDX_W-1:0] pos;
  logic signed [VAL_W-1:0] v;
  logic        [ST_W-1:0]  res_status;
  logic signed [VAL_W-1:0] res_data;

  logic [CW-1:0]    left, right, len_x;
  logic [IDX_W-1:0] parent, big_idx, count_m1, len_m1, idx_addr;
  logic [CNT_W-1:0] count_dec, len_dec;
  logic [XW-1:0]    idx_x, cnt_x;
  logic             right_ok, big_r;
  logic signed [VAL_W-1:0] big_val;

  // Tree navigation around the hole.
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + CW'(1);
  assign len_x     = CW'(len);
  assign parent    = (pos - IDX_W'(1)) >> 1;
  assign right_ok  = right < len_x;
  assign count_dec = entry_count - CNT_W'(1);
  assign len_dec   = len - CNT_W'(1);
  assign count_m1  = count_dec[IDX_W-1:0];
  assign len_m1    = len_dec[IDX_W-1:0];
  assign idx_x     = XW'(read_index);
  assign cnt_x     = XW'(entry_count);
  assign idx_addr  = idx_x[IDX_W-1:0];

  // Larger child; the left one wins a tie.
  assign big_r   = right_ok && (rd_b > rd_a);
  assign big_val = big_r ? rd_b : rd_a;
  assign big_idx = big_r ? right[IDX_W-1:0] : left[IDX_W-1:0];

  // Status back to the controller.
  always_comb begin
    stat.full     = (entry_count == CNT_W'(CAPACITY));
    stat.empty    = (entry_count == '0);
    stat.idx_ok   = (idx_x < cnt_x);
    stat.pos_zero = (pos == '0);
    stat.left_out = (left >= len_x);
    stat.up_go    = (v > rd_a);
    stat.dn_go    = (v < big_val);
    stat.len_gt1  = (len > CNT_W'(1));
  end

  // Read address selection.
  always_comb begin
    if (ctl.rd_read) begin
      addr_a = idx_addr;
    end else if (ctl.up_rd) begin
      addr_a = parent;
    end else if (ctl.dn_rd) begin
      addr_a = left[IDX_W-1:0];
    end else begin
      addr_a = '0;
    end
    if (ctl.rd_del) begin
      addr_b = count_m1;
    end else if (ctl.sort_rd) begin
      addr_b = len_m1;
    end else begin
      addr_b = right[IDX_W-1:0];
    end
  end

  // Write port selection: all writes land in the hole except the sorted tail.
  always_comb begin
    wr_en   = ctl.wr_v | ctl.up_move | ctl.dn_move | ctl.sort_take;
    wr_addr = ctl.sort_take ? len_m1 : pos;
    if (ctl.wr_v) begin
      wr_data = v;
    end else if (ctl.dn_move) begin
      wr_data = big_val;
    end else begin
      wr_data = rd_a;
    end
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.ld_insert) begin
      entry_count <= entry_count + CNT_W'(1);
    end else if (ctl.del_take) begin
      entry_count <= count_dec;
    end
  end

  // Working registers and result.
  always_ff @(posedge clk) begin
    if (ctl.ld_insert) begin
      v   <= value;
      pos <= entry_count[IDX_W-1:0];
    end
    if (ctl.ld_sort) begin
      len <= entry_count;
    end
    if (ctl.del_take) begin
      v   <= rd_b;
      len <= count_dec;
      pos <= '0;
    end
    if (ctl.sort_take) begin
      v   <= rd_b;
      len <= len_dec;
      pos <= '0;
    end
    if (ctl.up_move) begin
      pos <= parent;
    end
    if (ctl.dn_move) begin
      pos <= big_idx;
    end
    if (ctl.res_load) begin
      res_status <= ctl.res_code;
      res_data   <= '0;
    end
    if (ctl.del_take || ctl.read_take) begin
      res_data <= rd_a;
    end
    if (ctl.publish) begin
      status <= res_status;
      data   <= res_data;
      count  <= cnt_x[CNT_OUT_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // The entry count stays within the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // Sift-up never moves past the root.
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    ctl.up_move |-> (pos != '0))
    else $error("sift-up step taken at the root");

  // An insert is only started while there is room for it.
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_insert |-> !stat.full)
    else $error("insert started on a full heap");
`endif

endmodule

FILE: sv/max_heap_priority_queue.sv
// Binary max-heap of signed 32-bit values with in-place heapsort. Each request
// (insert, delete maximum, heapsort, read entry) yields one result carrying a
// status, a data word and the entry count. One request is worked at a time;
// the next one is taken as soon as the current result sits in the output
// register. Entries live in a memory with one write port and two registered
// read ports, so each heap level visited is a read, then a compare-and-write.
// Depends on hpq_pkg, hpq_ctrl and hpq_dp.
module max_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic        [CMD_W-1:0]     cmd,
  input  logic signed [VAL_W-1:0]     value,
  input  logic        [RIDX_W-1:0]    read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic        [ST_W-1:0]      status,
  output logic signed [VAL_W-1:0]     data,
  output logic        [CNT_OUT_W-1:0] count
);

  hpq_cmd_t  ctl;
  hpq_stat_t stat;

  // Sequencer for the sift and sort loops.
  hpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_code  (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Entry storage and compare logic.
  hpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .value      (value),
    .read_index (read_index),
    .status     (status),
    .data       (data),
    .count      (count)
  );

endmodule

FILE: test/tb_max_heap_priority_queue.sv
// Testbench for max_heap_priority_queue: directed and random insert, delete, heapsort and
// read requests, with every result checked against a heap model kept inside the bench.
// Depends on hpq_pkg and the max_heap_priority_queue RTL.
module tb_max_heap_priority_queue
  import hpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH      = DEF_CAPACITY;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RANDOM_PER_PHASE = 345;
  localparam int REPORT_LIMIT     = 10;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One expected result of the queue.
  typedef struct packed {
    logic [ST_W-1:0]         st;
    logic signed [VAL_W-1:0] word;
    logic [CNT_OUT_W-1:0]    cnt;
  } heap_result_t;

  // Heap model: tracks the stored entries and the queue of results still owed.
  class heap_ledger_t;
    logic signed [VAL_W-1:0] slots [QUEUE_DEPTH];
    int unsigned held;
    heap_result_t pending [$];
    int unsigned failures;
    int unsigned checked;
    int unsigned refused_full;
    int unsigned refused_empty;
    int unsigned out_of_range;
    int unsigned op_tally [4];

    function new();
      held = 0;
      failures = 0;
      checked = 0;
      refused_full = 0;
      refused_empty = 0;
      out_of_range = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [VAL_W-1:0] t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    // Move an entry toward the root while it beats its parent.
    function void float_up(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (slots[pos] <= slots[parent]) break;
        swap_slots(pos, parent);
        pos = parent;
      end
    endfunction

    // Move an entry toward the leaves while it is strictly below its larger child.
    // Equal children resolve to the left one.
    function void sink(int unsigned pos, int unsigned len);
      int unsigned lchild;
      int unsigned larger;
      while (1) begin
        lchild = 2 * pos + 1;
        if (lchild >= len) break;
        larger = lchild;
        if (lchild + 1 < len && slots[lchild + 1] > slots[lchild]) larger = lchild + 1;
        if (slots[pos] >= slots[larger]) break;
        swap_slots(pos, larger);
        pos = larger;
      end
    endfunction

    // Apply an accepted request to the model and queue the result it owes.
    function void note_request(logic [CMD_W-1:0] op, logic signed [VAL_W-1:0] v,
                               logic [RIDX_W-1:0] ix);
      heap_result_t r;
      int unsigned len;
      r.st = ST_OK;
      r.word = '0;
      op_tally[op]++;
      case (op)
        CMD_INSERT: begin
          if (held >= QUEUE_DEPTH) begin
            r.st = ST_FULL;
            refused_full++;
          end else begin
            slots[held] = v;
            float_up(held);
            held++;
          end
        end
        CMD_DELETE: begin
          if (held == 0) begin
            r.st = ST_EMPTY;
            refused_empty++;
          end else begin
            swap_slots(0, held - 1);
            held--;
            r.word = slots[held];
            sink(0, held);
          end
        end
        CMD_SORT: begin
          len = held;
          while (len > 1) begin
            swap_slots(0, len - 1);
            len--;
            sink(0, len);
          end
        end
        default: begin
          if (ix < held) begin
            r.word = slots[ix];
          end else begin
            r.st = ST_RANGE;
            out_of_range++;
          end
        end
      endcase
      r.cnt = CNT_OUT_W'(held);
      pending.push_back(r);
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] word,
                               logic [CNT_OUT_W-1:0] cnt);
      heap_result_t want;
      checked++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("[%0t] result with nothing owed: status %0d data %0d count %0d",
                   $time, st, $signed(word), cnt);
        return;
      end
      want = pending.pop_front();
      if (want.st !== st || want.word !== word || want.cnt !== cnt) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("[%0t] result %0d mismatch: status %0d/%0d data %0d/%0d %s %s",
                   $time, checked, want.st, st, $signed(want.word), $signed(word),
                   $sformatf("count %0d/%0d", want.cnt, cnt), "(expected/actual)");
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic        [CMD_W-1:0]     cmd;
  logic signed [VAL_W-1:0]     value;
  logic        [RIDX_W-1:0]    read_index;
  logic                        out_valid;
  logic                        out_ready;
  logic        [ST_W-1:0]      status;
  logic signed [VAL_W-1:0]     data;
  logic        [CNT_OUT_W-1:0] count;

  heap_ledger_t ledger;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  idle_cycles;

  max_heap_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .read_index(read_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .count     (count)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Result side: stall at random, check every accepted result.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.check_result(status, data, count);
  end

  // Watchdog on cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results still owed",
               idle_cycles, ledger.pending.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one request from a falling edge, with random idle cycles ahead of it,
  // and return at the falling edge after it is accepted.
  task automatic send_request(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] v,
                              input logic [RIDX_W-1:0] ix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    value      <= v;
    read_index <= ix;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(op, v, ix);
    @(negedge clk);
  endtask

  // Insert values: extremes, a narrow band that produces ties, and full-range words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return VAL_MAX;
    if (roll < 10) return VAL_MIN;
    if (roll < 14) return '0;
    if (roll < 40) return VAL_W'(int'($urandom_range(0, 8)) - 4);
    return VAL_W'($urandom);
  endfunction

  // Read positions: mostly held entries, the rest anywhere in the field.
  function automatic logic [RIDX_W-1:0] pick_index();
    if (ledger.held > 0 && $urandom_range(0, 99) < 75)
      return RIDX_W'($urandom_range(0, ledger.held - 1));
    return RIDX_W'($urandom_range(0, 15));
  endfunction

  // Edge cases: empty queue, single entry, extremes, ties, reads out of range,
  // and inserts and deletes on a sorted store.
  task automatic run_directed();
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_READ, '0, 4'd0);
    send_request(CMD_SORT, '0, '0);
    send_request(CMD_INSERT, VAL_MIN, '0);
    send_request(CMD_SORT, '0, '0);
    send_request(CMD_READ, '0, 4'd0);
    send_request(CMD_INSERT, VAL_MAX, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, -32'sd1, '0);
    send_request(CMD_INSERT, -32'sd1, '0);
    send_request(CMD_INSERT, 32'sd5, '0);
    send_request(CMD_READ, '0, 4'd15);
    send_request(CMD_READ, '0, 4'd4);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_SORT, '0, '0);
    send_request(CMD_READ, '0, 4'd0);
    send_request(CMD_READ, '0, 4'd3);
    send_request(CMD_INSERT, 32'sd7, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_READ, '0, 4'd14);
  endtask

  // Bursts of inserts and deletes walk the queue between empty and full; sorts are
  // followed by reads of the sorted store; a share of fully random requests is mixed in.
  task automatic run_random(input int unsigned quota);
    int unsigned issued;
    int unsigned roll;
    int unsigned burst;
    issued = 0;
    while (issued < quota) begin
      roll  = $urandom_range(0, 99);
      burst = $urandom_range(1, 16);
      for (int unsigned k = 0; k < burst && issued < quota; k++) begin
        if (roll < 35)
          send_request(CMD_INSERT, pick_value(), RIDX_W'($urandom_range(0, 15)));
        else if (roll < 65)
          send_request(CMD_DELETE, VAL_W'($urandom), RIDX_W'($urandom_range(0, 15)));
        else if (roll < 80)
          send_request(CMD_READ, VAL_W'($urandom), pick_index());
        else if (roll < 90)
          send_request((k == 0) ? CMD_SORT : CMD_READ, VAL_W'($urandom), pick_index());
        else
          send_request(CMD_W'($urandom_range(0, 3)), pick_value(),
                       RIDX_W'($urandom_range(0, 15)));
        issued++;
      end
    end
  endtask

  // Main sequence: reset, directed requests, three random phases with different
  // stall patterns, then wait for the last results.
  initial begin
    ledger        = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    cmd           = CMD_INSERT;
    value         = '0;
    read_index    = '0;
    idle_cycles   = 0;
    send_idle_pct = 21;
    recv_idle_pct = 47;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(RANDOM_PER_PHASE);
    send_idle_pct = 47;
    recv_idle_pct = 21;
    run_random(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d insert, %0d delete, %0d sort, %0d read; %s",
             ledger.op_tally[CMD_INSERT] + ledger.op_tally[CMD_DELETE] +
             ledger.op_tally[CMD_SORT] + ledger.op_tally[CMD_READ],
             ledger.op_tally[CMD_INSERT], ledger.op_tally[CMD_DELETE],
             ledger.op_tally[CMD_SORT], ledger.op_tally[CMD_READ],
             $sformatf("%0d results checked.", ledger.checked));
    $display("Refused: %0d inserts when full, %0d deletes when empty, %s",
             ledger.refused_full, ledger.refused_empty,
             $sformatf("%0d reads out of range; %0d failures.",
                       ledger.out_of_range, ledger.failures));
    if (ledger.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/hpq_pkg.sv
sv/hpq_ctrl.sv
sv/hpq_dp.sv
sv/max_heap_priority_queue.sv
test/tb_max_heap_priority_queue.sv
